// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the SHA-1 byte stream hasher.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbh check failed");

// Next-cycle implication.
`define SBH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbh check failed");

`endif

// ----- src/sbh_pkg.sv -----
// Package of the SHA-1 byte stream hasher: sizes, round and initial constants,
// controller state types and the command/status structs. No dependencies.
`default_nettype none

package sbh_pkg;

    localparam int WordW      = 32;
    localparam int NumWords   = 5;
    localparam int BlockWords = 16;
    localparam int Rounds     = 80;
    localparam int CountW     = 61;
    localparam int RoundW     = 7;
    localparam int IdxW       = 3;

    typedef logic [WordW-1:0] word_t;

    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    localparam word_t InitChain [NumWords] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        AFT_DATA,
        AFT_PAD,
        AFT_FINAL
    } after_t;

    typedef struct packed {
        logic place_byte;
        logic place_pad;
        logic place_len;
        logic load_vars;
        logic round_step;
        logic add_chain;
        logic out_step;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic block_full;
        logic pad_spill;
        logic round_done;
        logic out_done;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/sbh_ctrl.sv -----
// Controller of the SHA-1 byte stream hasher: input handshake, block and
// padding sequence, digest output. Depends on sbh_pkg.
`default_nettype none

module sbh_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         byte_present,
    input  wire logic         end_of_message,
    input  wire logic         out_stall,
    input  wire sbh_pkg::stat_t stat,
    output sbh_pkg::cmd_t     cmd,
    output logic              in_stall,
    output logic              out_valid
);
    import sbh_pkg::*;

    state_t state_reg, state_next;
    after_t after_reg, after_next;
    logic   pend_reg, pend_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= AFT_DATA;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && stat.block_full)
                    begin
                        state_next = ST_LOAD;
                        after_next = AFT_DATA;
                        pend_next  = end_of_message;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (stat.pad_spill)
                begin
                    state_next = ST_LOAD;
                    after_next = AFT_PAD;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_LOAD;
                after_next = AFT_FINAL;
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (stat.round_done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                unique case (after_reg)
                    AFT_DATA:  state_next = pend_reg ? ST_PAD : ST_IDLE;
                    AFT_PAD:   state_next = ST_LEN;
                    AFT_FINAL: state_next = ST_OUT;
                    default:   state_next = ST_IDLE;
                endcase
                pend_next = 1'b0;
            end
            ST_OUT:
            begin
                if (!out_stall && stat.out_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.place_byte = accept && byte_present;
            end
            ST_PAD:
            begin
                cmd.place_pad = 1'b1;
            end
            ST_LEN:
            begin
                cmd.place_len = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load_vars = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
            end
            ST_OUT:
            begin
                out_valid    = 1'b1;
                cmd.out_step = !out_stall;
                cmd.restart  = !out_stall && stat.out_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/sbh_datapath.sv -----
// Datapath of the SHA-1 byte stream hasher: block window and schedule,
// round logic, chaining value, byte count and digest word select. Depends on sbh_pkg.
`default_nettype none

module sbh_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sbh_pkg::cmd_t               cmd,
    input  wire logic [7:0]                  data_byte,
    output sbh_pkg::stat_t                   stat,
    output logic [sbh_pkg::WordW-1:0]        digest_word,
    output logic [sbh_pkg::IdxW-1:0]         word_number,
    output logic                             last_word
);
    import sbh_pkg::*;

    word_t              win_reg   [BlockWords];
    word_t              win_next  [BlockWords];
    word_t              cv_reg    [NumWords];
    word_t              cv_next   [NumWords];
    word_t              v_reg     [NumWords];
    word_t              v_next    [NumWords];
    logic [CountW-1:0]  count_reg, count_next;
    logic [RoundW-1:0]  round_reg, round_next;
    logic [IdxW-1:0]    idx_reg, idx_next;

    logic [5:0]         pos;
    logic [3:0]         slot;
    logic [4:0]         shamt;
    logic [63:0]        bit_len;
    word_t              f_val;
    word_t              k_val;
    word_t              tmp;
    word_t              sched;

    assign pos     = count_reg[5:0];
    assign slot    = pos[5:2];
    assign shamt   = {~pos[1:0], 3'b000};
    assign bit_len = {count_reg, 3'b000};

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k_val = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K3;
        end
        tmp   = {v_reg[0][26:0], v_reg[0][31:27]} + f_val + v_reg[4] + k_val + win_reg[0];
        sched = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    end

    always_comb
    begin
        win_next   = win_reg;
        cv_next    = cv_reg;
        v_next     = v_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;

        if (cmd.place_byte)
        begin
            win_next[slot] = win_reg[slot] | ({24'h0, data_byte} << shamt);
            count_next     = count_reg + 61'd1;
        end
        if (cmd.place_pad)
        begin
            win_next[slot] = win_reg[slot] | ({24'h0, PadByte} << shamt);
        end
        if (cmd.place_len)
        begin
            win_next[14] = bit_len[63:32];
            win_next[15] = bit_len[31:0];
        end
        if (cmd.load_vars)
        begin
            v_next = cv_reg;
        end
        if (cmd.round_step)
        begin
            v_next[4] = v_reg[3];
            v_next[3] = v_reg[2];
            v_next[2] = {v_reg[1][1:0], v_reg[1][31:2]};
            v_next[1] = v_reg[0];
            v_next[0] = tmp;
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[BlockWords-1] = {sched[30:0], sched[31]};
            round_next = round_reg + 7'd1;
        end
        if (cmd.add_chain)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                cv_next[i] = cv_reg[i] + v_reg[i];
            end
            for (int i = 0; i < BlockWords; i++)
            begin
                win_next[i] = '0;
            end
            round_next = '0;
        end
        if (cmd.out_step)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (cmd.restart)
        begin
            cv_next    = InitChain;
            count_next = '0;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BlockWords; i++)
            begin
                win_reg[i] <= '0;
            end
            for (int i = 0; i < NumWords; i++)
            begin
                v_reg[i] <= '0;
            end
            cv_reg    <= InitChain;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            cv_reg    <= cv_next;
            v_reg     <= v_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    assign stat.block_full = &pos;
    assign stat.pad_spill  = (pos >= 6'd56);
    assign stat.round_done = (round_reg == RoundW'(Rounds - 1));
    assign stat.out_done   = (idx_reg == IdxW'(NumWords - 1));

    assign digest_word = cv_reg[idx_reg];
    assign word_number = idx_reg;
    assign last_word   = stat.out_done;

endmodule

`default_nettype wire

// ----- src/sha1_byte_stream_hasher.sv -----
// SHA-1 byte stream hasher: a message enters one byte per input transaction,
// the 160-bit digest leaves as five 32-bit output transactions.
// Input channel: in_valid/in_stall with data_byte, byte_present and
// end_of_message. A transaction with byte_present low carries no byte; with
// end_of_message high it closes the message (alone, it hashes the empty message).
// Output channel: out_valid/out_stall with digest_word, word_number (0 is the
// most significant word) and last_word, high on word 4.
// A byte that does not fill a block is taken without a stall. The 64th byte of a
// block stalls the input for one load, 80 rounds of the single shared round unit
// and one chaining add. After the closing transaction padding places the pad byte
// and the length and hashes the last block, with an extra block when the message
// length mod 64 is 56 or more, then the five words follow, one per cycle while out_stall is low.
// A stalled output holds its word; no input is taken until word 4 is taken,
// after which the block is ready for the next message.
// Reset loads the initial chaining value, clears the block and the byte count.
// Depends on sbh_pkg, sbh_ctrl, sbh_datapath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sha1_byte_stream_hasher (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          byte_present,
    input  wire logic                          end_of_message,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sbh_pkg::WordW-1:0]          digest_word,
    output logic [sbh_pkg::IdxW-1:0]           word_number,
    output logic                               last_word
);
    import sbh_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sbh_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_stall      (out_stall),
        .stat           (stat),
        .cmd            (cmd),
        .in_stall       (in_stall),
        .out_valid      (out_valid)
    );

    sbh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .stat        (stat),
        .digest_word (digest_word),
        .word_number (word_number),
        .last_word   (last_word)
    );

    `SBH_ASSERT_NOW(a_no_input_during_output, out_valid, in_stall)
    `SBH_ASSERT_NEXT(a_digest_ends, out_valid && !out_stall && last_word, !out_valid && !in_stall)
    `SBH_ASSERT_NEXT(a_word_advance, out_valid && !out_stall && !last_word, out_valid && (word_number == $past(word_number) + 3'd1))
    `SBH_ASSERT_NOW(a_last_word_index, out_valid && last_word, word_number == 3'd4)

endmodule

`default_nettype wire
